FILE: design/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

	typedef enum logic [3:0] {
		OP_RED = 4'd0,
		OP_ADD = 4'd1,
		OP_SUB = 4'd2,
		OP_MUL = 4'd3,
		OP_DIV = 4'd4,
		OP_EQ  = 4'd5,
		OP_NE  = 4'd6,
		OP_LT  = 4'd7,
		OP_GT  = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_ZDEN = 2'd1,
		ERR_DIV0 = 2'd2,
		ERR_OVF  = 2'd3
	} err_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_PREP,
		ST_GCD,
		ST_GSHL,
		ST_DIVN,
		ST_DIVD,
		ST_RANGE,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

FILE: design/rational_arithmetic_unit.sv
// Rational arithmetic unit: cross-multiply, binary gcd and reduction by shared datapath.
//
//  channel | signals                                   | flow
//  --------+-------------------------------------------+------------------------
//  in      | in_valid in_stall op a_num a_den b_num b_den | one beat per fraction pair
//  out     | out_valid out_stall res_num res_den truth error | one beat per input beat
//
//  Errors, eq and ne go from IDLE straight to FIN; lt and gt pass MUL0-MUL2 and PREP.
//  Arithmetic ops add binary gcd, gcd shift-back, two divisions and a range check (a
//  zero numerator ends at PREP): one 33x33 multiplier in MUL0-MUL2, one 64-bit subtract
//  per binary gcd step, and one restoring divider bit per cycle, twice 64.
//  in_stall is high while an item is in work; the output register holds a
//  finished beat under out_stall while the next input beat is taken.
`default_nettype none
module rational_arithmetic_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         op,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic [30:0]        b_den,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic               truth,
	output logic [1:0]         error
);

	localparam logic [63:0] LIM = 64'd1 << (VALUE_WIDTH - 1);

	rau_pkg::state_t state_q, state_d;
	rau_pkg::op_t    op_q, op_in;
	rau_pkg::err_t   er_q;

	logic signed [32:0] an_q, ad_q, bn_q;
	logic [30:0]        bd_q;
	logic signed [63:0] p0_q, p1_q, p2_q;
	logic [63:0]        u_q, v_q, mn_q, md_q, r_q, dq_q;
	logic [5:0]         k_q, cnt_q;
	logic               neg_q;
	logic [31:0]        rn_q;
	logic [30:0]        rd_q;
	logic               tr_q;

	logic signed [31:0] out_num_q;
	logic [30:0]        out_den_q;
	logic               out_tr_q;
	logic [1:0]         out_er_q;
	logic               out_valid_q;

	logic signed [32:0] an_in, ad_in, mx, my;
	logic signed [65:0] prod;
	logic signed [63:0] num, den;
	logic [63:0]        mag_n, mag_d, diff, nm, dq_nx;
	logic               u_gt, eq_in, zden, div0, quick, arith_in, ge, fin_go;
	logic [64:0]        t, tsub;

	assign op_in = rau_pkg::op_t'(op);
	assign an_in = a_den[31] ? -{a_num[31], a_num} : {a_num[31], a_num};
	assign ad_in = a_den[31] ? -{a_den[31], a_den} : {a_den[31], a_den};
	assign eq_in = (an_in == {b_num[31], b_num}) && (ad_in == {2'b00, b_den});
	assign zden  = (a_den == 32'sd0) || ((op_in != rau_pkg::OP_RED) && (b_den == 31'd0));
	assign div0  = (op_in == rau_pkg::OP_DIV) && (b_num == 32'sd0);
	assign arith_in = (op_in == rau_pkg::OP_RED) || (op_in == rau_pkg::OP_ADD) ||
		(op_in == rau_pkg::OP_SUB) || (op_in == rau_pkg::OP_MUL) ||
		(op_in == rau_pkg::OP_DIV) || (op_in == rau_pkg::OP_LT) ||
		(op_in == rau_pkg::OP_GT);
	assign quick = !arith_in || zden || div0;

	always_comb begin
		mx = '0;
		my = '0;
		case (state_q)
			rau_pkg::ST_MUL0: begin
				mx = an_q;
				case (op_q)
					rau_pkg::OP_MUL: my = bn_q;
					rau_pkg::OP_RED: my = 33'sd1;
					default:         my = $signed({2'b00, bd_q});
				endcase
			end
			rau_pkg::ST_MUL1: begin
				if (op_q inside {rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_LT,
						rau_pkg::OP_GT}) begin
					mx = bn_q;
					my = ad_q;
				end
			end
			rau_pkg::ST_MUL2: begin
				mx = ad_q;
				case (op_q)
					rau_pkg::OP_DIV: my = bn_q;
					rau_pkg::OP_RED: my = 33'sd1;
					default:         my = $signed({2'b00, bd_q});
				endcase
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
	end

	assign prod  = mx * my;
	assign num   = (op_q == rau_pkg::OP_SUB) ? (p0_q - p1_q) : (p0_q + p1_q);
	assign den   = p2_q;
	assign mag_n = num[63] ? (64'd0 - 64'(num)) : 64'(num);
	assign mag_d = den[63] ? (64'd0 - 64'(den)) : 64'(den);
	assign u_gt  = u_q > v_q;
	assign diff  = u_gt ? (u_q - v_q) : (v_q - u_q);
	assign t     = {r_q, dq_q[63]};
	assign ge    = t >= {1'b0, u_q};
	assign tsub  = t - {1'b0, u_q};
	assign dq_nx = {dq_q[62:0], ge};
	assign nm    = neg_q ? (64'd0 - mn_q) : mn_q;
	assign fin_go = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rau_pkg::ST_IDLE:
				if (in_valid) begin
					state_d = quick ? rau_pkg::ST_FIN : rau_pkg::ST_MUL0;
				end
			rau_pkg::ST_MUL0: state_d = rau_pkg::ST_MUL1;
			rau_pkg::ST_MUL1: state_d = rau_pkg::ST_MUL2;
			rau_pkg::ST_MUL2: state_d = rau_pkg::ST_PREP;
			rau_pkg::ST_PREP: begin
				if (op_q == rau_pkg::OP_LT || op_q == rau_pkg::OP_GT || mag_n == 64'd0) begin
					state_d = rau_pkg::ST_FIN;
				end else begin
					state_d = rau_pkg::ST_GCD;
				end
			end
			rau_pkg::ST_GCD:   if (v_q == 64'd0) state_d = rau_pkg::ST_GSHL;
			rau_pkg::ST_GSHL:  if (k_q == 6'd0) state_d = rau_pkg::ST_DIVN;
			rau_pkg::ST_DIVN:  if (&cnt_q) state_d = rau_pkg::ST_DIVD;
			rau_pkg::ST_DIVD:  if (&cnt_q) state_d = rau_pkg::ST_RANGE;
			rau_pkg::ST_RANGE: state_d = rau_pkg::ST_FIN;
			rau_pkg::ST_FIN:   if (fin_go) state_d = rau_pkg::ST_IDLE;
			default:           state_d = rau_pkg::ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != rau_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rau_pkg::ST_FIN && fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rau_pkg::ST_FIN && fin_go) begin
			out_num_q <= rn_q;
			out_den_q <= rd_q;
			out_tr_q  <= tr_q;
			out_er_q  <= er_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rau_pkg::ST_IDLE: begin
				if (in_valid) begin
					op_q <= op_in;
					an_q <= an_in;
					ad_q <= ad_in;
					bn_q <= {b_num[31], b_num};
					bd_q <= b_den;
					rn_q <= '0;
					rd_q <= '0;
					if (!arith_in && !(op_in inside {rau_pkg::OP_EQ, rau_pkg::OP_NE})) begin
						er_q <= rau_pkg::ERR_NONE;
						tr_q <= 1'b0;
					end else if (zden) begin
						er_q <= rau_pkg::ERR_ZDEN;
						tr_q <= 1'b0;
					end else if (div0) begin
						er_q <= rau_pkg::ERR_DIV0;
						tr_q <= 1'b0;
					end else begin
						er_q <= rau_pkg::ERR_NONE;
						tr_q <= (op_in == rau_pkg::OP_EQ) ? eq_in :
							((op_in == rau_pkg::OP_NE) ? !eq_in : 1'b0);
					end
				end
			end
			rau_pkg::ST_MUL0: p0_q <= prod[63:0];
			rau_pkg::ST_MUL1: p1_q <= prod[63:0];
			rau_pkg::ST_MUL2: p2_q <= prod[63:0];
			rau_pkg::ST_PREP: begin
				u_q   <= mag_n;
				v_q   <= mag_d;
				mn_q  <= mag_n;
				md_q  <= mag_d;
				neg_q <= num[63] ^ den[63];
				k_q   <= '0;
				if (op_q == rau_pkg::OP_LT) begin
					tr_q <= p0_q < p1_q;
				end else if (op_q == rau_pkg::OP_GT) begin
					tr_q <= p1_q < p0_q;
				end else if (mag_n == 64'd0) begin
					rn_q <= '0;
					rd_q <= 31'd1;
				end
			end
			rau_pkg::ST_GCD: begin
				if (v_q != 64'd0) begin
					if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 6'd1;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else begin
						if (u_gt) begin
							u_q <= v_q;
						end
						v_q <= diff;
					end
				end
			end
			rau_pkg::ST_GSHL: begin
				if (k_q != 6'd0) begin
					u_q <= u_q << 1;
					k_q <= k_q - 6'd1;
				end else begin
					dq_q  <= mn_q;
					r_q   <= '0;
					cnt_q <= '0;
				end
			end
			rau_pkg::ST_DIVN, rau_pkg::ST_DIVD: begin
				cnt_q <= cnt_q + 6'd1;
				if (&cnt_q && state_q == rau_pkg::ST_DIVN) begin
					mn_q <= dq_nx;
					dq_q <= md_q;
					r_q  <= '0;
				end else begin
					r_q  <= ge ? tsub[63:0] : t[63:0];
					dq_q <= dq_nx;
					if (&cnt_q) begin
						md_q <= dq_nx;
					end
				end
			end
			rau_pkg::ST_RANGE: begin
				if (md_q > LIM - 64'd1 || mn_q > (neg_q ? LIM : LIM - 64'd1)) begin
					er_q <= rau_pkg::ERR_OVF;
				end else begin
					rn_q <= nm[31:0];
					rd_q <= md_q[30:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign res_num   = out_num_q;
	assign res_den   = out_den_q;
	assign truth     = out_tr_q;
	assign error     = out_er_q;

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the rational arithmetic unit: predicted fractions, flags and stalls.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_WIDTH = 32;
	localparam int IDLE_LIMIT  = 6000;
	localparam int HOLD_LEN    = 700;

	typedef struct {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic               truth;
		rau_pkg::err_t      error;
	} fraction_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [3:0]         op;
	logic signed [31:0] a_num;
	logic signed [31:0] a_den;
	logic signed [31:0] b_num;
	logic [30:0]        b_den;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] res_num;
	logic [30:0]        res_den;
	logic               truth;
	logic [1:0]         error;

	fraction_result_t pending_results[$];
	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int idle_cycles;
	int hold_left;
	bit hold_req;

	rational_arithmetic_unit #(.VALUE_WIDTH(VALUE_WIDTH)) DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_stall(out_stall), .res_num(res_num),
		.res_den(res_den), .truth(truth), .error(error)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = y;
			y = x % y;
			x = t;
		end
		return x;
	endfunction

	function automatic rau_pkg::err_t reduce_fraction(longint num, longint den,
			output logic signed [31:0] rn, output logic [30:0] rd);
		bit          neg;
		logic [63:0] mn;
		logic [63:0] md;
		logic [63:0] g;
		logic [63:0] lim;
		neg = (num < 0) != (den < 0);
		mn = (num < 0) ? 64'(-num) : 64'(num);
		md = (den < 0) ? 64'(-den) : 64'(den);
		g = euclid_gcd(mn, md);
		lim = 64'd1 << (VALUE_WIDTH - 1);
		rn = '0;
		rd = '0;
		if (g != 0) begin
			mn = mn / g;
			md = md / g;
		end
		if (mn == 0)
			neg = 1'b0;
		if (md > lim - 1 || mn > (neg ? lim : lim - 1))
			return rau_pkg::ERR_OVF;
		rn = neg ? 32'(-mn) : 32'(mn);
		rd = md[30:0];
		return rau_pkg::ERR_NONE;
	endfunction

	function automatic fraction_result_t predict_fraction(logic [3:0] opc,
			logic signed [31:0] an_i, logic signed [31:0] ad_i,
			logic signed [31:0] bn_i, logic [30:0] bd_i);
		fraction_result_t r;
		longint an;
		longint ad;
		longint bn;
		longint bd;
		rau_pkg::err_t e;
		r.num = '0;
		r.den = '0;
		r.truth = 1'b0;
		r.error = rau_pkg::ERR_NONE;
		e = rau_pkg::ERR_NONE;
		if (opc > rau_pkg::OP_GT)
			return r;
		an = an_i;
		ad = ad_i;
		bn = bn_i;
		bd = longint'({33'b0, bd_i});
		if (ad < 0) begin
			an = -an;
			ad = -ad;
		end
		if (ad == 0 || (opc != rau_pkg::OP_RED && bd == 0)) begin
			r.error = rau_pkg::ERR_ZDEN;
			return r;
		end
		case (rau_pkg::op_t'(opc))
			rau_pkg::OP_RED: e = reduce_fraction(an, ad, r.num, r.den);
			rau_pkg::OP_ADD: e = reduce_fraction(an * bd + bn * ad, ad * bd, r.num, r.den);
			rau_pkg::OP_SUB: e = reduce_fraction(an * bd - bn * ad, ad * bd, r.num, r.den);
			rau_pkg::OP_MUL: e = reduce_fraction(an * bn, ad * bd, r.num, r.den);
			rau_pkg::OP_DIV: begin
				if (bn == 0)
					e = rau_pkg::ERR_DIV0;
				else
					e = reduce_fraction(an * bd, ad * bn, r.num, r.den);
			end
			rau_pkg::OP_EQ: r.truth = (an == bn && ad == bd);
			rau_pkg::OP_NE: r.truth = !(an == bn && ad == bd);
			rau_pkg::OP_LT: r.truth = (an * bd < bn * ad);
			default: r.truth = (bn * ad < an * bd);
		endcase
		if (e != rau_pkg::ERR_NONE) begin
			r.num = '0;
			r.den = '0;
			r.truth = 1'b0;
		end
		r.error = e;
		return r;
	endfunction

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_LEN;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		fraction_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat num=%0d den=%0d truth=%0b error=%0d",
					$time, res_num, res_den, truth, error);
			end else begin
				exp_r = pending_results.pop_front();
				if (res_num !== exp_r.num || res_den !== exp_r.den ||
						truth !== exp_r.truth || error !== exp_r.error) begin
					mismatches++;
					$display({"%0t: expected num=%0d den=%0d truth=%0b error=%0d,",
						" got num=%0d den=%0d truth=%0b error=%0d"},
						$time, exp_r.num, exp_r.den, exp_r.truth, exp_r.error,
						res_num, res_den, truth, error);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_item(logic [3:0] opc, logic signed [31:0] an,
			logic signed [31:0] ad, logic signed [31:0] bn, logic [30:0] bd);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= opc;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(predict_fraction(opc, an, ad, bn, bd));
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(4))
			0: return $urandom;
			1: return 32'($signed($urandom_range(40)) - 20);
			2: return 32'($signed($urandom_range(65535)) - 32768);
			3: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0000_0001;
				endcase
			end
			default: return 32'($urandom_range(1000)) * 32'($urandom_range(1000));
		endcase
	endfunction

	task automatic send_random();
		logic [3:0]  opc;
		logic [31:0] an;
		logic [31:0] ad;
		logic [31:0] bn;
		logic [30:0] bd;
		if ($urandom_range(49) == 0)
			opc = 4'($urandom_range(15, int'(rau_pkg::OP_GT) + 1));
		else
			opc = 4'($urandom_range(int'(rau_pkg::OP_GT)));
		an = pick_word();
		ad = pick_word();
		bn = pick_word();
		bd = 31'(pick_word());
		if ($urandom_range(1))
			bd = 31'($urandom_range(1, 200));
		if ($urandom_range(39) == 0)
			ad = '0;
		if ($urandom_range(39) == 0)
			bd = '0;
		if ((opc == rau_pkg::OP_EQ || opc == rau_pkg::OP_NE) && $urandom_range(1)) begin
			bn = an;
			bd = ad[30:0];
		end
		send_item(opc, an, ad, bn, bd);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_random();
		drain_results();
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_item(rau_pkg::OP_RED, 32'sd6, -32'sd4, 32'sd0, 31'd0);
		send_item(rau_pkg::OP_RED, 32'sd0, 32'sd7, 32'sd1, 31'd1);
		send_item(rau_pkg::OP_RED, 32'sh8000_0000, -32'sd1, 32'sd0, 31'd1);
		send_item(rau_pkg::OP_RED, 32'sh8000_0000, 32'sh8000_0000, 32'sd0, 31'd1);
		send_item(rau_pkg::OP_RED, 32'sd5, 32'sd0, 32'sd1, 31'd1);
		send_item(rau_pkg::OP_ADD, 32'sd1, 32'sd2, 32'sd1, 31'd0);
		send_item(rau_pkg::OP_ADD, 32'sd1, 32'sd2, 32'sd1, 31'd3);
		send_item(rau_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sd1, 32'sh7FFF_FFFF, 31'd1);
		send_item(rau_pkg::OP_SUB, 32'sd1, 32'sd2, 32'sd1, 31'd2);
		send_item(rau_pkg::OP_SUB, 32'sh8000_0000, 32'sd1, 32'sh7FFF_FFFF,
			31'h7FFF_FFFF);
		send_item(rau_pkg::OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			31'h7FFF_FFFF);
		send_item(rau_pkg::OP_MUL, -32'sd3, 32'sd4, 32'sd8, 31'd9);
		send_item(rau_pkg::OP_DIV, 32'sd3, 32'sd4, 32'sd0, 31'd1);
		send_item(rau_pkg::OP_DIV, 32'sd3, 32'sd4, -32'sd9, 31'd8);
		send_item(rau_pkg::OP_EQ, 32'sd2, 32'sd3, 32'sd2, 31'd3);
		send_item(rau_pkg::OP_EQ, 32'sd2, -32'sd3, 32'sd2, 31'd3);
		send_item(rau_pkg::OP_NE, 32'sd2, 32'sd3, 32'sd2, 31'd3);
		send_item(rau_pkg::OP_LT, 32'sd1, 32'sd3, 32'sd1, 31'd2);
		send_item(rau_pkg::OP_LT, 32'sh8000_0000, 32'sd1, 32'sh7FFF_FFFF, 31'd1);
		send_item(rau_pkg::OP_GT, 32'sd1, 32'sd3, 32'sd1, 31'd2);
		send_item(rau_pkg::OP_GT, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1,
			31'h7FFF_FFFF);
		send_item(rau_pkg::OP_GT, 32'sd1, 32'sd0, 32'sd1, 31'd2);
		send_item(4'(int'(rau_pkg::OP_GT) + 1), 32'sd1, 32'sd1, 32'sd1, 31'd1);
		send_item(4'hF, 32'shFFFF_FFFF, 32'sd0, 32'shFFFF_FFFF, 31'h7FFF_FFFF);
		drain_results();
	endtask

	task automatic test_output_hold();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		repeat (12)
			send_random();
		drain_results();
	endtask

	task automatic test_sender_pause();
		send_idle_pct = 10;
		recv_stall_pct = 30;
		repeat (6)
			send_random();
		drain_results();
		repeat (6)
			send_random();
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		op = rau_pkg::OP_RED;
		a_num = '0;
		a_den = '0;
		b_num = '0;
		b_den = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		idle_cycles = 0;
		hold_left = 0;
		hold_req = 1'b0;
		repeat (12)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		run_phase(0, 0, 400);
		run_phase(55, 0, 400);
		run_phase(0, 55, 400);
		run_phase(27, 27, 400);
		test_output_hold();
		test_sender_pause();
		drain_results();
		repeat (400)
			@(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
